### sv/tbtm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tbtm_pkg: shared types and constants of the barycentric texel mapper
// Opcodes, sequencer states, fixed-point constants and register indexes.
// ----------------------------------------------------------------------------
package tbtm_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAX_DIM   = 4096;
  localparam int IDX_W     = 12;

  // Divider: integer quotient bits before overflow, quotient bits, dividend width
  localparam int DIV_PRE   = 31 - FRAC_BITS;
  localparam int DIV_STEPS = 31;
  localparam int DIV_W     = 64 + DIV_PRE;

  localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
  localparam logic signed [65:0] S32_MIN = -66'sd2147483648;
  localparam logic signed [65:0] ONE_FX  = 66'sd1 <<< FRAC_BITS;

  localparam logic [12:0] WIDTH_RESET  = 13'd1024;
  localparam logic [12:0] HEIGHT_RESET = 13'd1024;

  typedef enum logic [2:0] {
    OP_QUERY  = 3'd0,
    OP_ORIGIN = 3'd1,
    OP_EDGE_A = 3'd2,
    OP_EDGE_B = 3'd3,
    OP_TEX1   = 3'd4,
    OP_TEX2   = 3'd5,
    OP_TEX3   = 3'd6,
    OP_NONE   = 3'd7
  } opcode_t;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  // Sequencer states: each product step uses the shared multiplier once.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DOT,     // 15 products for the five dot products
    ST_DET,     // det and both numerators, two products each
    ST_DSET,    // divider setup and overflow check
    ST_DIV,     // one quotient bit per cycle
    ST_W0,
    ST_INTERP,  // six weight*coordinate products
    ST_SCALE,   // two products by the image size
    ST_DONE     // degenerate result
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    if (x > S32_MAX) return 32'sh7FFF_FFFF;
    if (x < S32_MIN) return 32'sh8000_0000;
    return $signed(x[31:0]);
  endfunction

endpackage
`default_nettype wire

### sv/triangle_barycentric_texel_mapper.sv
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_barycentric_texel_mapper
// Barycentric texture-coordinate mapper over one stored triangle.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: start with busy low; in_opcode selects a query point (0),
//   the origin (1), edge a (2), edge b (3) or a vertex texture coordinate
//   (4..6). Loads are registered, give no result and never raise
//   busy, so loads can go back to back; opcode 7 is ignored.
//   A query runs on one shared 33x33 multiplier and a restoring divider
//   under a sequencer: 15 dot-product steps, 6 det/numerator steps, two
//   divisions of 1 setup + 31 one-bit steps, 1 step for w0, 6 interpolation
//   steps and 2 scale steps (only the dot-product and det steps, then a done
//   step, when the determinant is zero). The result beat sits in the first
//   cycle with busy low again, and the next beat can be taken in that same
//   cycle.
//   Result beat: out_valid is high for one cycle with out_texel_u,
//   out_texel_v and out_degenerate. The receiver cannot stall.
//   Configuration: cfg_valid/cfg_ready, cfg_index 0 = width, 1 = height;
//   cfg_ready is always high. Write only while busy is low.
//   Reset (rst_n low, synchronous) clears the triangle to zero and sets
//   both image dimensions to 1024.
// ----------------------------------------------------------------------------
module triangle_barycentric_texel_mapper (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  output logic               busy,
  input  wire  [2:0]         in_opcode,
  input  wire  signed [31:0] in_comp_x,
  input  wire  signed [31:0] in_comp_y,
  input  wire  signed [31:0] in_comp_z,
  output logic               out_valid,
  output logic [11:0]        out_texel_u,
  output logic [11:0]        out_texel_v,
  output logic               out_degenerate,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire                cfg_index,
  input  wire  [12:0]        cfg_data
);
  import tbtm_pkg::*;

  // Triangle store
  logic signed [31:0] org_r [3];
  logic signed [31:0] ea_r  [3];
  logic signed [31:0] eb_r  [3];
  logic signed [31:0] tex_r [6];
  logic signed [31:0] d_r   [3];
  logic [12:0] width_r, height_r;

  // Sequencer
  state_t     state_r, state_nxt;
  logic [4:0] step_r, step_nxt;
  logic [2:0] dsel_r, dsel_nxt;       // dot product under way: aa ab bb da db
  logic       div_sel_r, div_sel_nxt; // 0: w1, 1: w2
  logic [1:0] comp;

  // Intermediate values
  logic signed [65:0] acc_r;
  logic signed [31:0] aa_r, ab_r, bb_r, da_r, db_r;
  logic signed [65:0] det_r, n1_r, n2_r;
  logic signed [31:0] w0_r, w1_r, w2_r, u_r, v_r;

  // Divider
  logic [63:0]          ud_r;
  logic [62:0]          dr_r;
  logic [DIV_STEPS-1:0] ds_r, dq_r;
  logic                 dneg_r, dover_r;
  logic [63:0]          num_mag, det_mag;
  logic                 ovf;
  logic [63:0]          rs;
  logic                 ge;
  logic [DIV_STEPS-1:0] q_full;
  logic signed [31:0]   w_q;

  // Shared 33x33 signed multiplier
  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;
  logic signed [65:0] acc_sum;
  logic signed [31:0] acc_fl;

  logic [12:0] wd, hd;

  function automatic logic [63:0] mag64(input logic signed [65:0] x);
    logic signed [65:0] a;
    a = (x < 0) ? -x : x;
    return a[63:0];
  endfunction

  // Truncated, clamped texel index
  function automatic logic [IDX_W-1:0] texel(input logic signed [65:0] p,
                                             input logic [12:0] dim);
    logic signed [65:0] t;
    t = (p < 0) ? -((-p) >>> FRAC_BITS) : (p >>> FRAC_BITS);
    if (t < 0) return '0;
    if (t >= $signed(66'(dim))) return IDX_W'(dim - 13'd1);
    return t[IDX_W-1:0];
  endfunction

  assign mp = ma * mb;

  always_comb begin
    wd = (width_r == 13'd0) ? 13'd1 :
         (width_r > 13'(MAX_DIM) ? 13'(MAX_DIM) : width_r);
    hd = (height_r == 13'd0) ? 13'd1 :
         (height_r > 13'(MAX_DIM) ? 13'(MAX_DIM) : height_r);
  end

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign comp      = step_r[1:0];

  // Multiplier operand mux
  always_comb begin
    ma = '0;
    mb = '0;
    case (state_r)
      ST_DOT: begin
        case (dsel_r)
          3'd0: begin ma = 33'(ea_r[comp]); mb = 33'(ea_r[comp]); end
          3'd1: begin ma = 33'(ea_r[comp]); mb = 33'(eb_r[comp]); end
          3'd2: begin ma = 33'(eb_r[comp]); mb = 33'(eb_r[comp]); end
          3'd3: begin ma = 33'(d_r[comp]);  mb = 33'(ea_r[comp]); end
          3'd4: begin ma = 33'(d_r[comp]);  mb = 33'(eb_r[comp]); end
          default: ;
        endcase
      end
      // aa*bb, ab*ab, bb*da, ab*db, aa*db, ab*da
      ST_DET: begin
        case (step_r)
          5'd0: begin ma = 33'(aa_r); mb = 33'(bb_r); end
          5'd1: begin ma = 33'(ab_r); mb = 33'(ab_r); end
          5'd2: begin ma = 33'(bb_r); mb = 33'(da_r); end
          5'd3: begin ma = 33'(ab_r); mb = 33'(db_r); end
          5'd4: begin ma = 33'(aa_r); mb = 33'(db_r); end
          5'd5: begin ma = 33'(ab_r); mb = 33'(da_r); end
          default: ;
        endcase
      end
      // u terms first, then v terms
      ST_INTERP: begin
        case (step_r)
          5'd0: begin ma = 33'(w0_r); mb = 33'(tex_r[0]); end
          5'd1: begin ma = 33'(w1_r); mb = 33'(tex_r[2]); end
          5'd2: begin ma = 33'(w2_r); mb = 33'(tex_r[4]); end
          5'd3: begin ma = 33'(w0_r); mb = 33'(tex_r[1]); end
          5'd4: begin ma = 33'(w1_r); mb = 33'(tex_r[3]); end
          5'd5: begin ma = 33'(w2_r); mb = 33'(tex_r[5]); end
          default: ;
        endcase
      end
      ST_SCALE: begin
        if (step_r[0] == 1'b0) begin
          ma = 33'(u_r);
          mb = $signed({20'd0, wd - 13'd1});
        end else begin
          ma = 33'(ONE_FX - 66'(v_r));
          mb = $signed({20'd0, hd});
        end
      end
      default: ;
    endcase
  end

  // Floored shift and saturation of the accumulated products
  assign acc_sum = acc_r + mp;
  assign acc_fl  = sat32(acc_sum >>> FRAC_BITS);

  // Divider setup: magnitudes and integer-part overflow
  always_comb begin
    num_mag = div_sel_r ? mag64(n2_r) : mag64(n1_r);
    det_mag = mag64(det_r);
    ovf     = (DIV_W'(num_mag) >= (DIV_W'(det_mag) << DIV_PRE));
  end

  // Divider restoring step and signed, saturated quotient
  always_comb begin
    rs     = {dr_r, ds_r[DIV_STEPS-1]};
    ge     = (rs >= ud_r);
    q_full = {dq_r[DIV_STEPS-2:0], ge};
    if (dover_r) w_q = dneg_r ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else if (dneg_r) w_q = -$signed({1'b0, q_full});
    else w_q = $signed({1'b0, q_full});
  end

  // Next state
  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    dsel_nxt    = dsel_r;
    div_sel_nxt = div_sel_r;
    case (state_r)
      ST_IDLE: begin
        if (start && in_opcode == OP_QUERY) begin
          state_nxt = ST_DOT;
          step_nxt  = '0;
          dsel_nxt  = '0;
        end
      end
      ST_DOT: begin
        if (step_r == 5'd2) begin
          step_nxt = '0;
          if (dsel_r == 3'd4) state_nxt = ST_DET;
          else dsel_nxt = dsel_r + 3'd1;
        end else step_nxt = step_r + 5'd1;
      end
      ST_DET: begin
        if (step_r == 5'd5) begin
          step_nxt    = '0;
          div_sel_nxt = 1'b0;
          state_nxt   = (det_r == '0) ? ST_DONE : ST_DSET;
        end else step_nxt = step_r + 5'd1;
      end
      ST_DSET: begin
        state_nxt = ST_DIV;
        step_nxt  = '0;
      end
      ST_DIV: begin
        if (step_r == 5'(DIV_STEPS - 1)) begin
          step_nxt = '0;
          if (div_sel_r) state_nxt = ST_W0;
          else begin
            state_nxt   = ST_DSET;
            div_sel_nxt = 1'b1;
          end
        end else step_nxt = step_r + 5'd1;
      end
      ST_W0: begin
        state_nxt = ST_INTERP;
        step_nxt  = '0;
      end
      ST_INTERP: begin
        if (step_r == 5'd5) begin
          state_nxt = ST_SCALE;
          step_nxt  = '0;
        end else step_nxt = step_r + 5'd1;
      end
      ST_SCALE: begin
        if (step_r == 5'd1) state_nxt = ST_IDLE;
        else step_nxt = step_r + 5'd1;
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      step_r    <= '0;
      dsel_r    <= '0;
      div_sel_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      step_r    <= step_nxt;
      dsel_r    <= dsel_nxt;
      div_sel_r <= div_sel_nxt;
    end
  end

  // Stores and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        org_r[i] <= '0; ea_r[i] <= '0; eb_r[i] <= '0;
      end
      for (int i = 0; i < 6; i++) tex_r[i] <= '0;
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_WIDTH) width_r <= cfg_data;
        else height_r <= cfg_data;
      end
      if (start && !busy) begin
        case (in_opcode)
          OP_ORIGIN: begin org_r[0] <= in_comp_x; org_r[1] <= in_comp_y; org_r[2] <= in_comp_z; end
          OP_EDGE_A: begin ea_r[0] <= in_comp_x; ea_r[1] <= in_comp_y; ea_r[2] <= in_comp_z; end
          OP_EDGE_B: begin eb_r[0] <= in_comp_x; eb_r[1] <= in_comp_y; eb_r[2] <= in_comp_z; end
          OP_TEX1:   begin tex_r[0] <= in_comp_x; tex_r[1] <= in_comp_y; end
          OP_TEX2:   begin tex_r[2] <= in_comp_x; tex_r[3] <= in_comp_y; end
          OP_TEX3:   begin tex_r[4] <= in_comp_x; tex_r[5] <= in_comp_y; end
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid      <= 1'b0;
      out_texel_u    <= '0;
      out_texel_v    <= '0;
      out_degenerate <= 1'b0;
      acc_r          <= '0;
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (start && in_opcode == OP_QUERY) begin
            d_r[0] <= sat32(66'(in_comp_x) - 66'(org_r[0]));
            d_r[1] <= sat32(66'(in_comp_y) - 66'(org_r[1]));
            d_r[2] <= sat32(66'(in_comp_z) - 66'(org_r[2]));
            acc_r  <= '0;
          end
        end
        ST_DOT: begin
          if (step_r == 5'd2) begin
            acc_r <= '0;
            case (dsel_r)
              3'd0: aa_r <= acc_fl;
              3'd1: ab_r <= acc_fl;
              3'd2: bb_r <= acc_fl;
              3'd3: da_r <= acc_fl;
              3'd4: db_r <= acc_fl;
              default: ;
            endcase
          end else acc_r <= acc_sum;
        end
        // Even steps load the first product, odd steps subtract the second
        ST_DET: begin
          case (step_r)
            5'd0, 5'd2, 5'd4: acc_r <= mp;
            5'd1: det_r <= acc_r - mp;
            5'd3: n1_r  <= acc_r - mp;
            5'd5: n2_r  <= acc_r - mp;
            default: ;
          endcase
        end
        // Quotient below 2^31 unless overflow, so start with un >> DIV_PRE
        ST_DSET: begin
          ud_r    <= det_mag;
          dr_r    <= 63'(num_mag >> DIV_PRE);
          ds_r    <= {num_mag[DIV_PRE-1:0], {FRAC_BITS{1'b0}}};
          dq_r    <= '0;
          dover_r <= ovf;
          dneg_r  <= (div_sel_r ? n2_r[65] : n1_r[65]) ^ det_r[65];
        end
        ST_DIV: begin
          dr_r <= ge ? 63'(rs - ud_r) : rs[62:0];
          ds_r <= {ds_r[DIV_STEPS-2:0], 1'b0};
          dq_r <= q_full;
          if (step_r == 5'(DIV_STEPS - 1)) begin
            if (div_sel_r) w2_r <= w_q;
            else w1_r <= w_q;
          end
        end
        ST_W0: begin
          w0_r  <= sat32(ONE_FX - 66'(w1_r) - 66'(w2_r));
          acc_r <= '0;
        end
        ST_INTERP: begin
          if (step_r == 5'd2) begin
            u_r   <= acc_fl;
            acc_r <= '0;
          end else if (step_r == 5'd5) begin
            v_r   <= acc_fl;
            acc_r <= '0;
          end else acc_r <= acc_sum;
        end
        ST_SCALE: begin
          if (step_r[0] == 1'b0) out_texel_u <= texel(mp, wd);
          else begin
            out_texel_v    <= texel(mp, hd);
            out_degenerate <= 1'b0;
            out_valid      <= 1'b1;
          end
        end
        ST_DONE: begin
          out_valid      <= 1'b1;
          out_texel_u    <= '0;
          out_texel_v    <= '0;
          out_degenerate <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

### sv/tbtm_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tbtm_checker: port-level checks of the texel mapper
// Watches the command and result beats on the top level's ports.
// ----------------------------------------------------------------------------
module tbtm_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        start,
  input wire        busy,
  input wire [2:0]  in_opcode,
  input wire        out_valid,
  input wire [11:0] out_texel_u,
  input wire [11:0] out_texel_v,
  input wire        out_degenerate
);
  import tbtm_pkg::*;

  // A load beat never makes the block busy
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_opcode != OP_QUERY) |=> !busy)
    else $error("load beat started a query");

  // A result beat is a single-cycle strobe
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // A degenerate result carries zero coordinates
  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |-> (out_texel_u == 12'd0 && out_texel_v == 12'd0))
    else $error("degenerate result with nonzero coordinates");

  // A query beat makes the block busy next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_opcode == OP_QUERY) |=> busy)
    else $error("query beat not taken");

endmodule

bind triangle_barycentric_texel_mapper tbtm_checker u_tbtm_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_opcode(in_opcode),
  .out_valid(out_valid), .out_texel_u(out_texel_u), .out_texel_v(out_texel_v),
  .out_degenerate(out_degenerate)
);
`default_nettype wire
